### design/integer_to_text_formatter_macros.svh
// Assertion macros for the integer-to-text formatter checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef INTEGER_TO_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TO_TEXT_FORMATTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define ITF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itf assertion failed");

// next-cycle implication, disabled in reset
`define ITF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itf assertion failed");

`endif

### design/itf_pkg.sv
// Shared constants, types and helpers for the integer-to-text formatter.
// Used by itf_digit_unit and integer_to_text_formatter; no dependencies.
package itf_pkg;

  localparam int DigitBuf = 32;
  localparam int DigIdxW  = $clog2(DigitBuf);
  localparam int DigCntW  = $clog2(DigitBuf + 1);
  localparam int PosW     = DigCntW;

  localparam logic [1:0] RadixBin = 2'd0;
  localparam logic [1:0] RadixDec = 2'd1;
  localparam logic [1:0] RadixHex = 2'd2;

  localparam int FlagLeft  = 0;
  localparam int FlagPlus  = 1;
  localparam int FlagSpace = 2;
  localparam int FlagZero  = 3;
  localparam int FlagUpper = 4;

  // floor(n * Recip10 / 2^35) == n / 10 for every 32-bit n
  localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;
  localparam int          RecipShft = 35;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;

  typedef struct packed {
    logic        start;
    logic [1:0]  radix;
    logic [31:0] mag;
  } itf_dig_req_t;

  typedef struct packed {
    logic       step;
    logic [3:0] digit;
    logic       done;
  } itf_dig_rsp_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      digit_char = CharZero + {4'b0000, d};
    end else begin
      base = upper ? CharUpA : CharLowA;
      digit_char = base + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

### design/integer_to_text_formatter.sv
// Top level of the printf-style integer-to-text formatter.
// Depends on itf_pkg and itf_digit_unit.
//
// One word in carries a 32-bit value and its format controls; the block
// answers with the formatted text, one ASCII byte per output word, tlast on
// the final byte (1 to 33 bytes). An item is accepted, then converted one
// digit per step: a single step per digit in binary or hex, a reciprocal
// multiply step then a remainder step per digit in decimal; a layout step
// follows, then one output byte per cycle when the sink does not stall.
// in_tready is high only between items; the last byte can still wait in the
// output register while the next item is taken.
module integer_to_text_formatter import itf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] value, [36:32] style_flags, [41:37] field_width, [46:42] min_digits
  input  logic [47:0] in_tdata,
  // [1:0] radix_sel, [2] signed_mode
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] text_byte
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_LAY  = 4'b0100,
    ST_EMIT = 4'b1000
  } st_state_t;

  st_state_t     state_r, state_nxt;
  logic [4:0]    flags_r, width_r, prec_r;
  logic [7:0]    sign_ch_r;
  logic          has_sign_r;
  logic [DigCntW-1:0] nd_r, nd_nxt;
  logic [3:0]    dig_mem [DigitBuf];
  logic [PosW-1:0] lead_r, zst_r, dst_r, dend_r, total_r;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r;
  logic          out_last_r;

  logic          in_fire;
  logic [31:0]   raw;
  logic          neg;
  itf_dig_req_t  dreq;
  itf_dig_rsp_t  drsp;

  logic [PosW-1:0] ndig, body, pad, lead, zst, zeros, dst, dend, total;
  logic            left, zpad;
  logic            load;
  logic [DigIdxW-1:0] dix;
  logic [PosW-1:0]    dix_full;
  logic [7:0]      ch;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign raw       = in_tdata[31:0];
  assign neg       = in_tuser[2] && raw[31];

  assign dreq.start = in_fire;
  assign dreq.radix = in_tuser[1:0];
  assign dreq.mag   = neg ? (32'd0 - raw) : raw;

  itf_digit_unit u_dig (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // layout boundaries: lead spaces | sign | zeros | digits | trailing spaces
  always_comb begin
    ndig  = (PosW'(prec_r) > nd_r) ? PosW'(prec_r) : nd_r;
    body  = ndig + PosW'(has_sign_r);
    pad   = (PosW'(width_r) > body) ? (PosW'(width_r) - body) : '0;
    left  = flags_r[FlagLeft];
    zpad  = !left && flags_r[FlagZero];
    lead  = (!left && !zpad) ? pad : '0;
    zst   = lead + PosW'(has_sign_r);
    zeros = (zpad ? pad : '0) + ndig - nd_r;
    dst   = zst + zeros;
    dend  = dst + nd_r;
    total = dend + (left ? pad : '0);
  end

  assign dix_full = dend_r - PosW'(1) - pos_r;
  assign dix      = dix_full[DigIdxW-1:0];

  // non-digit characters; digits come from the store in the output register
  always_comb begin
    if (pos_r < lead_r) begin
      ch = CharSpace;
    end else if (pos_r < zst_r) begin
      ch = sign_ch_r;
    end else if (pos_r < dst_r) begin
      ch = CharZero;
    end else begin
      ch = CharSpace;
    end
  end

  assign load = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    nd_nxt        = nd_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          nd_nxt    = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (drsp.step) begin
          nd_nxt = nd_r + DigCntW'(1);
          if (drsp.done) begin
            state_nxt = ST_LAY;
          end
        end
      end
      ST_LAY: begin
        pos_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + PosW'(1);
          if (pos_r == total_r - PosW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nd_r  <= nd_nxt;
    pos_r <= pos_nxt;
    if (in_fire) begin
      flags_r    <= in_tdata[36:32];
      width_r    <= in_tdata[41:37];
      prec_r     <= in_tdata[46:42];
      has_sign_r <= neg || in_tdata[32 + FlagPlus] || in_tdata[32 + FlagSpace];
      if (neg) begin
        sign_ch_r <= CharMinus;
      end else if (in_tdata[32 + FlagPlus]) begin
        sign_ch_r <= CharPlus;
      end else begin
        sign_ch_r <= CharSpace;
      end
    end
    if (state_r == ST_LAY) begin
      lead_r  <= lead;
      zst_r   <= zst;
      dst_r   <= dst;
      dend_r  <= dend;
      total_r <= total;
    end
  end

  // digit store, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (state_r == ST_CONV && drsp.step) begin
      dig_mem[nd_r[DigIdxW-1:0]] <= drsp.digit;
    end
    if (state_r == ST_EMIT && load) begin
      if (pos_r >= dst_r && pos_r < dend_r) begin
        out_data_r <= digit_char(dig_mem[dix], flags_r[FlagUpper]);
      end else begin
        out_data_r <= ch;
      end
      out_last_r <= (pos_r == total_r - PosW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### design/itf_digit_unit.sv
// Iterative digit extractor: one digit per step, least significant first.
// Decimal uses a reciprocal multiply then remainder fix; binary/hex shift.
// Depends on itf_pkg.
module itf_digit_unit import itf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  itf_dig_req_t req,
  output itf_dig_rsp_t rsp
);

  typedef enum logic [2:0] {
    DU_IDLE = 3'b001,
    DU_MUL  = 3'b010,
    DU_DIG  = 3'b100
  } du_state_t;

  du_state_t   state_r, state_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        dec_r, hex_r;
  logic [63:0] prod_r;
  logic [63:0] prod_nxt;
  logic [31:0] quo;
  logic [3:0]  q10_lo;
  logic [3:0]  digit;
  logic [31:0] next_mag;

  assign prod_nxt = mag_r * Recip10;
  assign quo      = 32'(prod_r[63:RecipShft]);
  // only the low nibble of q*10 matters since the remainder is below ten
  assign q10_lo   = {quo[0], 3'b000} + {quo[2:0], 1'b0};

  always_comb begin
    if (dec_r) begin
      digit    = mag_r[3:0] - q10_lo;
      next_mag = quo;
    end else if (hex_r) begin
      digit    = mag_r[3:0];
      next_mag = {4'b0000, mag_r[31:4]};
    end else begin
      digit    = {3'b000, mag_r[0]};
      next_mag = {1'b0, mag_r[31:1]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rsp.step  = 1'b0;
    rsp.digit = digit;
    rsp.done  = 1'b0;
    case (state_r)
      DU_IDLE: begin
        if (req.start) begin
          mag_nxt   = req.mag;
          state_nxt = (req.radix == RadixDec) ? DU_MUL : DU_DIG;
        end
      end
      DU_MUL: begin
        state_nxt = DU_DIG;
      end
      DU_DIG: begin
        rsp.step = 1'b1;
        mag_nxt  = next_mag;
        if (next_mag == 32'd0) begin
          rsp.done  = 1'b1;
          state_nxt = DU_IDLE;
        end else begin
          state_nxt = dec_r ? DU_MUL : DU_DIG;
        end
      end
      default: begin
        state_nxt = DU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    if (state_r == DU_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == DU_IDLE && req.start) begin
      dec_r <= (req.radix == RadixDec);
      hex_r <= (req.radix != RadixDec) && (req.radix != RadixBin);
    end
  end

endmodule

### design/itf_checker.sv
// Port-level checker for integer_to_text_formatter, attached by bind.
// Depends on integer_to_text_formatter_macros.svh.
`include "integer_to_text_formatter_macros.svh"

module itf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled output word holds
  `ITF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // an accepted item keeps the block busy on the next cycle
  `ITF_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // between items only the final byte of the previous number may still wait
  `ITF_ASSERT_SAME(a_idle_pending_last, in_tready && out_tvalid, out_tlast)

  // a delivered final byte is never followed by a word while no item came in
  `ITF_ASSERT_NEXT(a_no_stray_word, out_tvalid && out_tready && out_tlast && in_tready && !in_tvalid, !out_tvalid)

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);
